// ----- hdl/tkv_pkg.sv -----
`default_nettype none
package tkv_pkg;

  localparam int MAX_COLUMNS = 7;
  localparam int NAME_BYTES  = 8;
  localparam int LINE_BYTES  = 65536;

  localparam int OFS_W  = 16;
  localparam int NAME_W = 8 * NAME_BYTES;
  localparam int COL_W  = 3;
  localparam int KCNT_W = 4;

  localparam logic [7:0] TAB_BYTE = 8'd9;

  localparam logic [OFS_W-1:0] LINE_MAX = OFS_W'(LINE_BYTES - 1);

  localparam logic [KCNT_W-1:0] KEY_FULL = KCNT_W'(NAME_BYTES);
  localparam logic [KCNT_W-1:0] KEY_OVER = KCNT_W'(NAME_BYTES + 1);

  // Configuration register indexes
  localparam logic [2:0] REG_COLUMN_COUNT  = 3'd0;
  localparam logic [2:0] REG_COLUMN_NAME_0 = 3'd1;

  typedef logic [OFS_W-1:0] ofs_t;

  // Broadcast to every cell for one accepted byte
  typedef struct packed {
    logic              key_byte_en;
    logic              start_key;
    logic              end_key_en;
    logic              rec_en;
    logic              clear;
    logic              load_snap;
    logic              shift;
    logic [7:0]        data_byte;
    logic [KCNT_W-1:0] key_count;
    logic [KCNT_W-1:0] key_count_nx;
    ofs_t              rec_start;
    ofs_t              rec_len;
  } cell_ctrl_t;

  // One descriptor slot of the output chain
  typedef struct packed {
    ofs_t start;
    ofs_t len;
  } desc_t;

  function automatic logic [7:0] name_byte(input logic [NAME_W-1:0] name,
                                           input logic [2:0] k);
    name_byte = name[{k, 3'b000} +: 8];
  endfunction

endpackage
`default_nettype wire

// ----- hdl/tkv_cell.sv -----
`default_nettype none
module tkv_cell (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire tkv_pkg::cell_ctrl_t        ctrl_i,
  input  wire logic                       active_i,
  input  wire logic                       name_we_i,
  input  wire logic [tkv_pkg::NAME_W-1:0] name_data_i,
  input  wire logic                       claim_i,
  output logic                            claim_o,
  input  wire tkv_pkg::desc_t             slot_i,
  output tkv_pkg::desc_t                  slot_o
);

  logic [tkv_pkg::NAME_W-1:0] name_q;
  logic                       match_q, match_d;
  logic                       tgt_q, tgt_d;
  tkv_pkg::ofs_t              start_q, start_d;
  tkv_pkg::ofs_t              len_q, len_d;
  tkv_pkg::desc_t             slot_q;
  logic                       elig;

  always_comb begin
    match_d = match_q;
    if (ctrl_i.key_byte_en) begin
      if (ctrl_i.key_count < tkv_pkg::KEY_FULL) begin
        match_d = match_q &
          (tkv_pkg::name_byte(name_q, ctrl_i.key_count[2:0]) == ctrl_i.data_byte);
      end else begin
        match_d = 1'b0;
      end
    end
    // whole key must end where the name ends
    elig = active_i && match_d &&
           (ctrl_i.key_count_nx != '0) &&
           (ctrl_i.key_count_nx <= tkv_pkg::KEY_FULL) &&
           ((ctrl_i.key_count_nx == tkv_pkg::KEY_FULL) ||
            (tkv_pkg::name_byte(name_q, ctrl_i.key_count_nx[2:0]) == 8'd0));
    claim_o = claim_i || (ctrl_i.end_key_en && elig);
    tgt_d   = ctrl_i.end_key_en ? (elig && !claim_i) : tgt_q;
    start_d = (ctrl_i.rec_en && tgt_d) ? ctrl_i.rec_start : start_q;
    len_d   = (ctrl_i.rec_en && tgt_d) ? ctrl_i.rec_len : len_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      name_q  <= '0;
      match_q <= 1'b1;
      tgt_q   <= 1'b0;
      start_q <= '0;
      len_q   <= '0;
    end else begin
      if (name_we_i) begin
        name_q <= name_data_i;
      end
      if (ctrl_i.clear) begin
        match_q <= 1'b1;
        tgt_q   <= 1'b0;
        start_q <= '0;
        len_q   <= '0;
      end else begin
        match_q <= ctrl_i.start_key ? 1'b1 : match_d;
        tgt_q   <= tgt_d;
        start_q <= start_d;
        len_q   <= len_d;
      end
    end
  end

  // load the finished record, or take the neighbor's slot on a beat
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_snap) begin
      slot_q <= '{start: start_d, len: len_d};
    end else if (ctrl_i.shift) begin
      slot_q <= slot_i;
    end
  end

  assign slot_o = slot_q;

endmodule
`default_nettype wire

// ----- hdl/tsv_key_value_field_extractor.sv -----
`default_nettype none
// Channel  | Handshake               | Payload
// ---------+-------------------------+------------------------------------------
// in       | in_valid_i / in_ready_o | data_byte_i, end_of_line_i
// out      | out_valid_o/out_ready_i | column_index_o, value_start_o,
//          |                         | value_length_o, last_descriptor_o
// cfg      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One line byte is taken every cycle but for stalled line ends; a byte's
// effect on the column records settles in the cycle it is accepted, through
// the first-match priority chain that runs across the seven column cells.
// A line-ending beat loads the descriptor chain; while out_ready_i is high,
// descriptors leave its head one per cycle from the cycle after that beat.
// A line-ending beat stalls while descriptors of the previous line still wait,
// unless only the last one is left and it leaves in that same cycle; ordinary
// bytes are never stalled.
// Reset clears all records and parse state; the cfg port is always ready.
module tsv_key_value_field_extractor (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [7:0]                 data_byte_i,
  input  wire logic                       end_of_line_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [tkv_pkg::COL_W-1:0]       column_index_o,
  output logic [15:0]                     value_start_o,
  output logic [15:0]                     value_length_o,
  output logic                            last_descriptor_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [2:0]                 cfg_index_i,
  input  wire logic [tkv_pkg::NAME_W-1:0] cfg_data_i
);

  logic                         in_fire, out_fire, cfg_fire;
  logic [tkv_pkg::COL_W-1:0]    column_count_q;

  // line parse state
  tkv_pkg::ofs_t                pos_q, pos_nx;
  tkv_pkg::ofs_t                fs_q, fs_d;
  logic                         inval_q, inval_d;
  logic [tkv_pkg::KCNT_W-1:0]   kc_q, kc_nx, kc_d;
  logic                         is_tab;
  logic [tkv_pkg::OFS_W:0]      eol_len_w;

  // output chain state
  logic [tkv_pkg::COL_W-1:0]    cnt_q, cnt_d;
  logic [tkv_pkg::COL_W-1:0]    idx_q, idx_d;

  tkv_pkg::cell_ctrl_t          ctrl;
  logic                         claim [tkv_pkg::MAX_COLUMNS+1];
  tkv_pkg::desc_t               slot  [tkv_pkg::MAX_COLUMNS+1];

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_fire    = out_valid_o && out_ready_i;
  // hold a line end until the chain can be reloaded
  assign in_ready_o  = !end_of_line_i || (cnt_q == '0) ||
                       ((cnt_q == tkv_pkg::COL_W'(1)) && out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;

  assign is_tab = (data_byte_i == tkv_pkg::TAB_BYTE);
  assign pos_nx = (pos_q == tkv_pkg::LINE_MAX) ? pos_q : pos_q + 1'b1;
  assign eol_len_w = {1'b0, pos_q} + 1'b1 - {1'b0, fs_q};

  always_comb begin
    ctrl           = '0;
    ctrl.data_byte = data_byte_i;
    ctrl.key_count = kc_q;
    kc_nx          = kc_q;
    kc_d           = kc_q;
    inval_d        = inval_q;
    fs_d           = fs_q;
    if (in_fire) begin
      if (!inval_q) begin
        ctrl.key_byte_en = !is_tab;
        if (!is_tab) begin
          kc_nx = (kc_q < tkv_pkg::KEY_FULL) ? kc_q + 1'b1 : tkv_pkg::KEY_OVER;
        end
        kc_d = kc_nx;
        if (is_tab || end_of_line_i) begin
          ctrl.end_key_en = 1'b1;
          inval_d         = 1'b1;
          fs_d            = pos_nx;
          // key without value at line end records an empty value
          ctrl.rec_en     = end_of_line_i;
          ctrl.rec_start  = pos_nx;
          ctrl.rec_len    = '0;
        end
      end else if (is_tab) begin
        ctrl.rec_en    = 1'b1;
        ctrl.rec_start = fs_q;
        ctrl.rec_len   = (pos_q >= fs_q) ? pos_q - fs_q : '0;
        ctrl.start_key = 1'b1;
        inval_d        = 1'b0;
        kc_d           = '0;
      end else if (end_of_line_i) begin
        ctrl.rec_en    = 1'b1;
        ctrl.rec_start = fs_q;
        if ({1'b0, pos_q} + 1'b1 < {1'b0, fs_q}) begin
          ctrl.rec_len = '0;
        end else if (eol_len_w > {1'b0, tkv_pkg::LINE_MAX}) begin
          ctrl.rec_len = tkv_pkg::LINE_MAX;
        end else begin
          ctrl.rec_len = eol_len_w[tkv_pkg::OFS_W-1:0];
        end
      end
      if (end_of_line_i) begin
        ctrl.clear     = 1'b1;
        ctrl.load_snap = 1'b1;
        inval_d        = 1'b0;
        fs_d           = '0;
        kc_d           = '0;
      end
    end
    ctrl.key_count_nx = kc_nx;
    ctrl.shift        = out_fire;
  end

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (ctrl.load_snap) begin
      cnt_d = column_count_q;
      idx_d = '0;
    end else if (out_fire) begin
      cnt_d = cnt_q - 1'b1;
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_count_q <= '0;
      pos_q          <= '0;
      fs_q           <= '0;
      inval_q        <= 1'b0;
      kc_q           <= '0;
      cnt_q          <= '0;
      idx_q          <= '0;
    end else begin
      if (cfg_fire && (cfg_index_i == tkv_pkg::REG_COLUMN_COUNT)) begin
        column_count_q <= cfg_data_i[tkv_pkg::COL_W-1:0];
      end
      if (in_fire) begin
        pos_q <= end_of_line_i ? '0 : pos_nx;
      end
      fs_q    <= fs_d;
      inval_q <= inval_d;
      kc_q    <= kc_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
    end
  end

  // Column cells: claim ripples toward higher columns, slots drain toward cell 0
  assign claim[0]                    = 1'b0;
  assign slot[tkv_pkg::MAX_COLUMNS]  = '0;

  for (genvar c = 0; c < tkv_pkg::MAX_COLUMNS; c++) begin : g_cell
    tkv_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .active_i    (tkv_pkg::COL_W'(c) < column_count_q),
      .name_we_i   (cfg_fire &&
                    (cfg_index_i == tkv_pkg::REG_COLUMN_NAME_0 + tkv_pkg::COL_W'(c))),
      .name_data_i (cfg_data_i),
      .claim_i     (claim[c]),
      .claim_o     (claim[c+1]),
      .slot_i      (slot[c+1]),
      .slot_o      (slot[c])
    );
  end

  assign column_index_o    = idx_q;
  assign value_start_o     = slot[0].start;
  assign value_length_o    = slot[0].len;
  assign last_descriptor_o = (cnt_q == tkv_pkg::COL_W'(1));

  // a line end loads one descriptor per configured column
  a_load_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && end_of_line_i |=> cnt_q == $past(column_count_q))
    else $error("descriptor count not loaded on line end");

  // a beat in mid-burst advances the chain by exactly one
  a_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && (cnt_q > tkv_pkg::COL_W'(1)) |=>
      (cnt_q == $past(cnt_q) - 1'b1) && (idx_q == $past(idx_q) + 1'b1))
    else $error("descriptor chain did not advance by one");

  // a new line end never overwrites a burst still in progress
  a_no_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && end_of_line_i && (cnt_q > tkv_pkg::COL_W'(1)) |-> !in_ready_o)
    else $error("line end accepted over a pending burst");

  // parse state returns to expecting a key after every line end
  a_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && end_of_line_i |=> !inval_q && (kc_q == '0) && (pos_q == '0))
    else $error("parse state not cleared after line end");

endmodule
`default_nettype wire

// ----- dv/descriptor_checker.sv -----
`default_nettype none
module descriptor_checker (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic                       in_ready_i,
  input  wire logic [7:0]                 data_byte_i,
  input  wire logic                       end_of_line_i,
  input  wire logic                       out_valid_i,
  input  wire logic                       out_ready_i,
  input  wire logic [tkv_pkg::COL_W-1:0]  column_index_i,
  input  wire logic [15:0]                value_start_i,
  input  wire logic [15:0]                value_length_i,
  input  wire logic                       last_descriptor_i,
  input  wire logic                       cfg_valid_i,
  input  wire logic                       cfg_ready_i,
  input  wire logic [2:0]                 cfg_index_i,
  input  wire logic [tkv_pkg::NAME_W-1:0] cfg_data_i,
  output int                              pending_o,
  output int                              errors_o
);

  localparam logic [tkv_pkg::COL_W-1:0] NO_COLUMN = 3'd7;

  typedef struct packed {
    logic [tkv_pkg::COL_W-1:0] column;
    logic [15:0]               start;
    logic [15:0]               length;
    logic                      last;
  } descriptor_t;

  descriptor_t owed_descs [$];
  descriptor_t head;

  // Shadow of the column registers
  logic [2:0]                 used_columns;
  logic [tkv_pkg::NAME_W-1:0] names [tkv_pkg::MAX_COLUMNS];

  // Shadow of the line parser
  int unsigned                     line_offset;
  int unsigned                     field_start;
  int unsigned                     key_len;
  logic                            in_value;
  logic [tkv_pkg::MAX_COLUMNS-1:0] still_equal;
  logic [tkv_pkg::COL_W-1:0]       target;
  int unsigned                     rec_start [tkv_pkg::MAX_COLUMNS];
  int unsigned                     rec_len [tkv_pkg::MAX_COLUMNS];

  int mismatches = 0;
  int owed_count = 0;

  assign pending_o = owed_count;
  assign errors_o  = mismatches;

  task automatic report(input string what);
    $display("%0t descriptor_checker: %s", $time, what);
    mismatches++;
  endtask

  function automatic logic [15:0] clip16(input int unsigned v);
    return (v > 65535) ? 16'hFFFF : 16'(v);
  endfunction

  function automatic void new_key();
    key_len     = 0;
    still_equal = '1;
  endfunction

  function automatic void store(input int unsigned start, input int unsigned len);
    if (target != NO_COLUMN) begin
      rec_start[target] = start;
      rec_len[target]   = (len > tkv_pkg::LINE_BYTES - 1) ? tkv_pkg::LINE_BYTES - 1 : len;
    end
  endfunction

  function automatic void clear_line();
    line_offset = 0;
    in_value    = 1'b0;
    field_start = 0;
    target      = NO_COLUMN;
    new_key();
    for (int c = 0; c < tkv_pkg::MAX_COLUMNS; c++) begin
      rec_start[c] = 0;
      rec_len[c]   = 0;
    end
  endfunction

  // Advance the parser by one line byte; queue the descriptor burst on end of line.
  function automatic void absorb_byte(input logic [7:0] b, input logic eol);
    int unsigned pos;
    int unsigned nxt;
    int          n;
    descriptor_t d;
    pos = line_offset;
    nxt = (pos + 1 < tkv_pkg::LINE_BYTES) ? pos + 1 : tkv_pkg::LINE_BYTES - 1;
    n   = int'(used_columns);
    if (!in_value) begin
      if (b != tkv_pkg::TAB_BYTE) begin
        if (key_len < tkv_pkg::NAME_BYTES) begin
          for (int c = 0; c < tkv_pkg::MAX_COLUMNS; c++)
            if (names[c][8*key_len +: 8] != b) still_equal[c] = 1'b0;
          key_len++;
        end else begin
          still_equal = '0;
          key_len     = tkv_pkg::NAME_BYTES + 1;
        end
      end
      if (b == tkv_pkg::TAB_BYTE || eol) begin
        // walk downward so the lowest matching column wins
        target = NO_COLUMN;
        if (key_len > 0 && key_len <= tkv_pkg::NAME_BYTES)
          for (int c = n - 1; c >= 0; c--)
            if (still_equal[c] &&
                (key_len == tkv_pkg::NAME_BYTES || names[c][8*key_len +: 8] == 8'h00))
              target = tkv_pkg::COL_W'(c);
        in_value    = 1'b1;
        field_start = nxt;
        if (eol) store(nxt, 0);
      end
    end else if (b == tkv_pkg::TAB_BYTE) begin
      store(field_start, (pos >= field_start) ? pos - field_start : 0);
      in_value = 1'b0;
      new_key();
    end else if (eol) begin
      store(field_start, (pos + 1 >= field_start) ? pos + 1 - field_start : 0);
    end
    line_offset = nxt;
    if (eol) begin
      for (int c = 0; c < n; c++) begin
        d.column = tkv_pkg::COL_W'(c);
        d.start  = clip16(rec_start[c]);
        d.length = clip16(rec_len[c]);
        d.last   = (c == n - 1);
        owed_descs.push_back(d);
      end
      clear_line();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_columns = '0;
      for (int c = 0; c < tkv_pkg::MAX_COLUMNS; c++) names[c] = '0;
      owed_descs.delete();
      clear_line();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (owed_descs.size() == 0) begin
          report($sformatf("descriptor for column %0d with none owed", column_index_i));
        end else begin
          head = owed_descs.pop_front();
          if (column_index_i !== head.column)
            report($sformatf("column index got %0d want %0d", column_index_i, head.column));
          if (value_start_i !== head.start)
            report($sformatf("column %0d start got %0d want %0d",
                             head.column, value_start_i, head.start));
          if (value_length_i !== head.length)
            report($sformatf("column %0d length got %0d want %0d",
                             head.column, value_length_i, head.length));
          if (last_descriptor_i !== head.last)
            report($sformatf("column %0d last flag got %0b want %0b",
                             head.column, last_descriptor_i, head.last));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == tkv_pkg::REG_COLUMN_COUNT) used_columns = cfg_data_i[2:0];
        else names[cfg_index_i - tkv_pkg::REG_COLUMN_NAME_0] = cfg_data_i;
      end
      if (in_valid_i && in_ready_i) absorb_byte(data_byte_i, end_of_line_i);
    end
    owed_count = owed_descs.size();
  end

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`default_nettype none
module testbench;

  // Drive every input to a known level from time zero
  logic                          clk_i         = 1'b0;
  logic                          rst_ni        = 1'b0;
  logic                          in_valid_i    = 1'b0;
  logic                          in_ready_o;
  logic [7:0]                    data_byte_i   = 8'h01;
  logic                          end_of_line_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i   = 1'b0;
  logic [tkv_pkg::COL_W-1:0]     column_index_o;
  logic [15:0]                   value_start_o;
  logic [15:0]                   value_length_o;
  logic                          last_descriptor_o;
  logic                          cfg_valid_i   = 1'b0;
  logic                          cfg_ready_o;
  logic [2:0]                    cfg_index_i   = tkv_pkg::REG_COLUMN_COUNT;
  logic [tkv_pkg::NAME_W-1:0]    cfg_data_i    = '0;

  int owed_descs;
  int mismatches;

  // Idle rates in percent; only changed at a falling edge
  int send_idle_pct = 7;
  int recv_idle_pct = 64;

  // Column names as last loaded, used to build keys that hit them
  logic [tkv_pkg::NAME_W-1:0] col_names [tkv_pkg::MAX_COLUMNS];
  logic [7:0]                 line_q [$];
  int                         bytes_sent;

  tsv_key_value_field_extractor dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .end_of_line_i     (end_of_line_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .column_index_o    (column_index_o),
    .value_start_o     (value_start_o),
    .value_length_o    (value_length_o),
    .last_descriptor_o (last_descriptor_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  descriptor_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .end_of_line_i     (end_of_line_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .column_index_i    (column_index_o),
    .value_start_i     (value_start_o),
    .value_length_i    (value_length_o),
    .last_descriptor_i (last_descriptor_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .pending_o         (owed_descs),
    .errors_o          (mismatches)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Stall the descriptor side at random, at the current receiver rate
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Hard stop: far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("testbench: errors");
    $finish;
  end

  function automatic logic [tkv_pkg::NAME_W-1:0] pack_name(input string s);
    logic [tkv_pkg::NAME_W-1:0] name;
    name = '0;
    for (int k = 0; k < s.len(); k++) name[8*k +: 8] = s[k];
    return name;
  endfunction

  // Bias name bytes toward a few values so keys collide with names often
  function automatic logic [7:0] name_char();
    logic [7:0] b;
    case ($urandom_range(0, 4))
      0: b = "a";
      1: b = "b";
      2: b = 8'hFF;
      3: b = 8'h80;
      default: begin
        b = 8'($urandom_range(1, 255));
        if (b == tkv_pkg::TAB_BYTE) b = "c";
      end
    endcase
    return b;
  endfunction

  function automatic logic [7:0] value_char();
    logic [7:0] b;
    b = 8'($urandom_range(1, 255));
    return (b == tkv_pkg::TAB_BYTE) ? 8'h20 : b;
  endfunction

  // Mostly short names from the biased alphabet; now and then a full random word
  function automatic logic [tkv_pkg::NAME_W-1:0] random_name();
    logic [tkv_pkg::NAME_W-1:0] name;
    int                         len;
    name = '0;
    if ($urandom_range(0, 7) == 0) return {$urandom, $urandom};
    len = $urandom_range(1, tkv_pkg::NAME_BYTES);
    for (int k = 0; k < len; k++) name[8*k +: 8] = name_char();
    return name;
  endfunction

  // Hold the beat until accepted; leave valid high so the next beat can follow
  // without a bubble. Idle gaps drop valid before the beat is offered.
  task automatic send_byte(input logic [7:0] b, input logic eol);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    data_byte_i   <= b;
    end_of_line_i <= eol;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_text(input string s, input logic eol_at_end);
    for (int k = 0; k < s.len(); k++)
      send_byte(s[k], eol_at_end && (k == s.len() - 1));
  endtask

  task automatic write_reg(input logic [2:0] idx,
                           input logic [tkv_pkg::NAME_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Write the column count and every name from col_names, back to back
  task automatic load_columns(input logic [2:0] count);
    write_reg(tkv_pkg::REG_COLUMN_COUNT, tkv_pkg::NAME_W'(count));
    for (int c = 0; c < tkv_pkg::MAX_COLUMNS; c++)
      write_reg(3'(tkv_pkg::REG_COLUMN_NAME_0 + c), col_names[c]);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold off the sender until every owed descriptor has come out, then wait so
  // that a line that owes nothing can retire before anything else moves.
  task automatic settle(input int next_send_pct, input int next_recv_pct);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (owed_descs != 0);
    send_idle_pct = next_send_pct;
    recv_idle_pct = next_recv_pct;
    repeat (4) @(posedge clk_i);
  endtask

  // Append a key: mostly a configured name, else a near miss, empty or overlong
  task automatic append_key();
    int         kind;
    int         col;
    int         klen;
    logic [7:0] b;
    kind = $urandom_range(0, 9);
    col  = $urandom_range(0, tkv_pkg::MAX_COLUMNS - 1);
    klen = 0;
    if (kind <= 7) begin
      // copy the name up to its first zero byte
      for (int k = 0; k < tkv_pkg::NAME_BYTES; k++) begin
        b = col_names[col][8*k +: 8];
        if (b == 8'h00) break;
        line_q.push_back((b == tkv_pkg::TAB_BYTE) ? 8'h41 : b);
        klen++;
      end
      // one byte too many, or one too few
      if (kind == 6) line_q.push_back(name_char());
      if (kind == 7 && klen > 0) void'(line_q.pop_back());
    end else if (kind == 9) begin
      // random key, overlong now and then
      klen = $urandom_range(1, tkv_pkg::NAME_BYTES + 3);
      repeat (klen) line_q.push_back(name_char());
    end
  endtask

  task automatic append_value();
    repeat ($urandom_range(0, 5)) line_q.push_back(value_char());
  endtask

  // Build one line, mostly well formed key/value pairs, and send it with the
  // end-of-line flag on its final byte.
  task automatic send_random_line();
    int pairs;
    line_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      // noise: tabs and name-like bytes in no order
      repeat ($urandom_range(1, 12))
        line_q.push_back(($urandom_range(0, 1) == 0) ? tkv_pkg::TAB_BYTE : name_char());
    end else begin
      pairs = $urandom_range(0, 3);
      repeat (pairs) begin
        append_key();
        line_q.push_back(tkv_pkg::TAB_BYTE);
        append_value();
        line_q.push_back(tkv_pkg::TAB_BYTE);
      end
      // vary how the line ends: inside a key, on a key's tab,
      // on a value's tab, or inside a value
      case ($urandom_range(0, 3))
        0: append_key();
        1: begin
          append_key();
          line_q.push_back(tkv_pkg::TAB_BYTE);
        end
        2: begin
          append_key();
          line_q.push_back(tkv_pkg::TAB_BYTE);
          append_value();
          line_q.push_back(tkv_pkg::TAB_BYTE);
        end
        default: begin
          append_key();
          line_q.push_back(tkv_pkg::TAB_BYTE);
          append_value();
        end
      endcase
    end
    if (line_q.size() == 0) line_q.push_back(name_char());
    foreach (line_q[k]) send_byte(line_q[k], k == line_q.size() - 1);
    bytes_sent += line_q.size();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Phase one: sender idles rarely, receiver often.
    // Directed setup: two columns named alike so the lower one wins, a
    // one-byte name, a full eight-byte name, an empty name that can never
    // match, an all-ones name, and a name with a zero inside it.
    col_names[0] = pack_name("id");
    col_names[1] = pack_name("x");
    col_names[2] = pack_name("abcdefgh");
    col_names[3] = pack_name("id");
    col_names[4] = '0;
    col_names[5] = '1;
    col_names[6] = 64'h0000_0000_0062_0071;
    load_columns(3'(tkv_pkg::MAX_COLUMNS));

    // later equal key overrides; line ends inside a value
    send_text("id\ta\tid\tbc", 1'b1);
    // empty key skips its value; a key at end of line gets an empty value
    send_text("\tz\tx", 1'b1);
    // eight all-ones bytes fill a whole name; line ends on the key's tab
    repeat (tkv_pkg::NAME_BYTES) send_byte(8'hFF, 1'b0);
    send_byte(tkv_pkg::TAB_BYTE, 1'b1);
    // empty value, line ends on the value's tab
    send_text("x\t\t", 1'b1);

    bytes_sent = 0;
    while (bytes_sent < 50) send_random_line();
    settle(64, 7);

    // Phase two: sender idles often, receiver rarely.
    // With no columns a line owes nothing but must still clear the parser.
    load_columns(3'd0);
    send_random_line();
    settle(64, 7);

    foreach (col_names[c]) col_names[c] = random_name();
    load_columns(3'd3);
    bytes_sent = 0;
    while (bytes_sent < 50) send_random_line();
    settle(0, 0);

    // Phase three: no idling on either side.
    foreach (col_names[c]) col_names[c] = random_name();
    load_columns(3'd1);
    bytes_sent = 0;
    while (bytes_sent < 20) send_random_line();
    settle(0, 0);

    foreach (col_names[c]) col_names[c] = random_name();
    col_names[0] = pack_name("id");
    col_names[1] = pack_name("k");
    load_columns(3'(tkv_pkg::MAX_COLUMNS));

    // two hits in one line, the second value ends the line
    send_text("id\tvv\tk\tv", 1'b1);

    bytes_sent = 0;
    while (bytes_sent < 45) send_random_line();
    settle(0, 0);

    // Let any stray descriptor surface before the verdict
    repeat (16) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
